/* rtl/core/perlin_gradient_noise_3d_top_defines.svh */
// ----------------------------------------------------------------------------
// perlin_gradient_noise_3d_top_defines
// assertion macros used by the noise core
// ----------------------------------------------------------------------------
`ifndef PERLIN_GRADIENT_NOISE_3D_TOP_DEFINES_SVH
`define PERLIN_GRADIENT_NOISE_3D_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PGN3_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define PGN3_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define PGN3_ASSERT_IMPLY(label, a, b)
`define PGN3_ASSERT_NEXT(label, a, b)
`endif
`endif

/* rtl/core/pgn3_pkg.sv */
// ----------------------------------------------------------------------------
// pgn3_pkg
// shared types and constants of the gradient noise core
// ----------------------------------------------------------------------------
package pgn3_pkg;

  localparam int TABLE_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = 2;
  localparam logic [3:0] OCT_RESET = 4'd7;

  typedef enum logic [1:0] {
    MODE_LOAD_PERM = 2'd0,
    MODE_LOAD_GRAD = 2'd1,
    MODE_NOISE     = 2'd2,
    MODE_TURB      = 2'd3
  } mode_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    mode_t              mode;
    logic [1:0]         axis_select;
    logic [7:0]         entry_index;
    logic [7:0]         perm_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic [3:0]         last_oct;
  } item_t;

  typedef struct packed {
    logic       v;
    logic       last_corner;
    logic       last_oct;
    logic       turb;
    logic [3:0] oct;
  } tag_t;

endpackage

/* rtl/core/perlin_gradient_noise_3d_top.sv */
// ----------------------------------------------------------------------------
// perlin_gradient_noise_3d_top
// 3d gradient noise and turbulence, signed q16.16, with loadable tables
// ----------------------------------------------------------------------------
// channel  ports                          handshake
// in       start, busy, in_*              start & !busy
// out      out_valid, out_*               one-cycle strobe, no back pressure
// cfg      cfg_valid, cfg_ready, cfg_*    cfg_valid & cfg_ready
//
// a load is popped without starting the engine, a noise item issues its eight
// lattice corners one a cycle through the corner pipeline, a turbulence item
// issues eight corners for each octave of the clamped octave_count
// no table clear after reset, entries hold anything until loaded
// busy rises only when the four-entry queue ahead of the engine is full
module perlin_gradient_noise_3d_top #(
  parameter int TABLE_BITS  = pgn3_pkg::TABLE_BITS_DEF,
  parameter int FRAC_BITS   = pgn3_pkg::FRAC_BITS_DEF,
  parameter int MAX_OCTAVES = pgn3_pkg::MAX_OCTAVES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_axis_select,
  input  logic [7:0]         in_entry_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  output logic signed [31:0] out_noise_value,
  output logic               out_was_turbulence,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_octave_count
);

  pgn3_pkg::item_t item, head;
  logic            full, empty, pop;

  assign busy = full;

  pgn3_front #(.MAX_OCTAVES(MAX_OCTAVES)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_octave_count (cfg_octave_count),
    .in_mode          (in_mode),
    .in_axis_select   (in_axis_select),
    .in_entry_index   (in_entry_index),
    .in_perm_value    (in_perm_value),
    .in_grad_x        (in_grad_x),
    .in_grad_y        (in_grad_y),
    .in_grad_z        (in_grad_z),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .item             (item)
  );

  pgn3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !full),
    .push_item (item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  pgn3_back #(.TABLE_BITS(TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (empty),
    .q_head             (head),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_noise_value    (out_noise_value),
    .out_was_turbulence (out_was_turbulence)
  );

endmodule

/* rtl/core/pgn3_front.sv */
// ----------------------------------------------------------------------------
// pgn3_front
// packs items, holds the octave register and clamps the turbulence depth
// ----------------------------------------------------------------------------
module pgn3_front #(
  parameter int MAX_OCTAVES = pgn3_pkg::MAX_OCTAVES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_octave_count,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_axis_select,
  input  logic [7:0]         in_entry_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output pgn3_pkg::item_t    item
);

  logic [3:0] oct_r;
  logic [3:0] oct_nxt;
  logic [3:0] oct_eff;

  assign cfg_ready = 1'b1;

  always_comb begin
    oct_nxt = oct_r;
    if (cfg_valid) begin
      oct_nxt = cfg_octave_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r <= pgn3_pkg::OCT_RESET;
    end else begin
      oct_r <= oct_nxt;
    end
  end

  always_comb begin
    oct_eff = oct_r;
    if (oct_r == 4'd0) begin
      oct_eff = 4'd1;
    end else if ({1'b0, oct_r} > 5'(MAX_OCTAVES)) begin
      oct_eff = 4'(MAX_OCTAVES);
    end
  end

  always_comb begin
    item.mode        = pgn3_pkg::mode_t'(in_mode);
    item.axis_select = in_axis_select;
    item.entry_index = in_entry_index;
    item.perm_value  = in_perm_value;
    item.grad_x      = in_grad_x;
    item.grad_y      = in_grad_y;
    item.grad_z      = in_grad_z;
    item.pos_x       = in_pos_x;
    item.pos_y       = in_pos_y;
    item.pos_z       = in_pos_z;
    item.last_oct    = (pgn3_pkg::mode_t'(in_mode) == pgn3_pkg::MODE_TURB) ?
                       oct_eff - 4'd1 : 4'd0;
  end

endmodule

/* rtl/core/pgn3_queue.sv */
// ----------------------------------------------------------------------------
// pgn3_queue
// small fifo between the front and the noise engine
// ----------------------------------------------------------------------------
module pgn3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pgn3_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pgn3_pkg::item_t head
);

  pgn3_pkg::item_t                mem_r [pgn3_pkg::QUEUE_DEPTH];
  logic [pgn3_pkg::QPTR_W-1:0]    wptr_r;
  logic [pgn3_pkg::QPTR_W-1:0]    rptr_r;
  logic [pgn3_pkg::QPTR_W:0]      cnt_r;

  assign full  = (cnt_r == (pgn3_pkg::QPTR_W+1)'(pgn3_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/core/pgn3_back.sv */
// ----------------------------------------------------------------------------
// pgn3_back
// table storage and corner pipeline: one lattice corner issued per cycle
// ----------------------------------------------------------------------------
`include "perlin_gradient_noise_3d_top_defines.svh"
module pgn3_back #(
  parameter int TABLE_BITS = pgn3_pkg::TABLE_BITS_DEF,
  parameter int FRAC_BITS  = pgn3_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pgn3_pkg::item_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  output logic signed [31:0] out_noise_value,
  output logic               out_was_turbulence
);

  localparam int TB    = TABLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int TSIZE = 1 << TB;
  localparam int POS_W = (TB + F > 32) ? TB + F : 32;
  localparam int NZ_W  = F + 10;
  localparam int ACC_W = F + 12;

  // tables
  logic [TB-1:0] perm_x_mem [TSIZE];
  logic [TB-1:0] perm_y_mem [TSIZE];
  logic [TB-1:0] perm_z_mem [TSIZE];
  logic [47:0]   grad_mem   [TSIZE];

  // gradient write is registered and lands on the same edge as the last corner's gradient read
  logic          grad_we_r;
  logic [TB-1:0] grad_waddr_r;
  logic [47:0]   grad_wdata_r;

  // issue state
  logic             active_r, active_nxt;
  logic [2:0]       corner_r, corner_nxt;
  logic [3:0]       oct_r, oct_nxt;
  logic [3:0]       last_oct_r, last_oct_nxt;
  logic             turb_r, turb_nxt;
  logic [POS_W-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;

  logic             item_end;
  logic             is_load;
  logic [TB+7:0]    idx_ext, val_ext, px_ext, py_ext, pz_ext;
  logic [TB-1:0]    widx, wval;
  logic [POS_W+31:0] ipx, ipy, ipz;

  assign item_end = active_r && (corner_r == 3'd7) && (oct_r == last_oct_r);
  assign q_pop    = !q_empty && (!active_r || item_end);
  assign is_load  = (q_head.mode == pgn3_pkg::MODE_LOAD_PERM) ||
                    (q_head.mode == pgn3_pkg::MODE_LOAD_GRAD);
  assign idx_ext  = {{TB{1'b0}}, q_head.entry_index};
  assign val_ext  = {{TB{1'b0}}, q_head.perm_value};
  assign widx     = idx_ext[TB-1:0];
  assign wval     = val_ext[TB-1:0];
  assign ipx      = {{POS_W{1'b0}}, q_head.pos_x};
  assign ipy      = {{POS_W{1'b0}}, q_head.pos_y};
  assign ipz      = {{POS_W{1'b0}}, q_head.pos_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_we_r <= 1'b0;
    end else begin
      grad_we_r <= q_pop && (q_head.mode == pgn3_pkg::MODE_LOAD_GRAD);
    end
    grad_waddr_r <= widx;
    grad_wdata_r <= {q_head.grad_x, q_head.grad_y, q_head.grad_z};
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.mode == pgn3_pkg::MODE_LOAD_PERM) begin
      case (q_head.axis_select)
        pgn3_pkg::AXIS_X: perm_x_mem[widx] <= wval;
        pgn3_pkg::AXIS_Y: perm_y_mem[widx] <= wval;
        pgn3_pkg::AXIS_Z: perm_z_mem[widx] <= wval;
        default: ;
      endcase
    end
    if (grad_we_r) begin
      grad_mem[grad_waddr_r] <= grad_wdata_r;
    end
  end

  always_comb begin
    active_nxt   = active_r;
    corner_nxt   = corner_r;
    oct_nxt      = oct_r;
    last_oct_nxt = last_oct_r;
    turb_nxt     = turb_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    pz_nxt       = pz_r;
    if (active_r) begin
      corner_nxt = corner_r + 3'd1;
      if (corner_r == 3'd7) begin
        oct_nxt = oct_r + 4'd1;
        px_nxt  = {px_r[POS_W-2:0], 1'b0};
        py_nxt  = {py_r[POS_W-2:0], 1'b0};
        pz_nxt  = {pz_r[POS_W-2:0], 1'b0};
      end
      if (item_end) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      active_nxt   = !is_load;
      corner_nxt   = 3'd0;
      oct_nxt      = 4'd0;
      last_oct_nxt = q_head.last_oct;
      turb_nxt     = (q_head.mode == pgn3_pkg::MODE_TURB);
      px_nxt       = ipx[POS_W-1:0];
      py_nxt       = ipy[POS_W-1:0];
      pz_nxt       = ipz[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    corner_r   <= corner_nxt;
    oct_r      <= oct_nxt;
    last_oct_r <= last_oct_nxt;
    turb_r     <= turb_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
  end

  // stage 0: permutation reads and fraction squares
  pgn3_pkg::tag_t s0_tag;
  logic [TB-1:0]  ax, ay, az;
  logic [F-1:0]   ux, uy, uz;
  logic [2*F-1:0] sqx, sqy, sqz;

  assign ux  = px_r[F-1:0];
  assign uy  = py_r[F-1:0];
  assign uz  = pz_r[F-1:0];
  assign ax  = px_r[TB+F-1:F] + {{(TB-1){1'b0}}, corner_r[2]};
  assign ay  = py_r[TB+F-1:F] + {{(TB-1){1'b0}}, corner_r[1]};
  assign az  = pz_r[TB+F-1:F] + {{(TB-1){1'b0}}, corner_r[0]};
  assign sqx = ux * ux;
  assign sqy = uy * uy;
  assign sqz = uz * uz;

  always_comb begin
    s0_tag.v           = active_r;
    s0_tag.last_corner = (corner_r == 3'd7);
    s0_tag.last_oct    = (oct_r == last_oct_r);
    s0_tag.turb        = turb_r;
    s0_tag.oct         = oct_r;
  end

  pgn3_pkg::tag_t s1_tag;
  logic [2:0]     s1_c;
  logic [TB-1:0]  s1_pxv, s1_pyv, s1_pzv;
  logic [F-1:0]   s1_ux, s1_uy, s1_uz, s1_u2x, s1_u2y, s1_u2z;

  always_ff @(posedge clk) begin
    s1_pxv <= perm_x_mem[ax];
    s1_pyv <= perm_y_mem[ay];
    s1_pzv <= perm_z_mem[az];
    s1_c   <= corner_r;
    s1_ux  <= ux;
    s1_uy  <= uy;
    s1_uz  <= uz;
    s1_u2x <= sqx[2*F-1:F];
    s1_u2y <= sqy[2*F-1:F];
    s1_u2z <= sqz[2*F-1:F];
  end

  // stage 1: gradient read and hermite weights
  logic [TB-1:0]    gaddr;
  logic [F+1:0]     tx, ty, tz;
  logic [2*F+1:0]   hpx, hpy, hpz;

  assign gaddr = s1_pxv ^ s1_pyv ^ s1_pzv;
  assign tx    = {2'b11, {F{1'b0}}} - {1'b0, s1_ux, 1'b0};
  assign ty    = {2'b11, {F{1'b0}}} - {1'b0, s1_uy, 1'b0};
  assign tz    = {2'b11, {F{1'b0}}} - {1'b0, s1_uz, 1'b0};
  assign hpx   = s1_u2x * tx;
  assign hpy   = s1_u2y * ty;
  assign hpz   = s1_u2z * tz;

  pgn3_pkg::tag_t s2_tag;
  logic [2:0]     s2_c;
  logic [47:0]    s2_g;
  logic [F:0]     s2_hx, s2_hy, s2_hz;
  logic [F-1:0]   s2_ux, s2_uy, s2_uz;

  always_ff @(posedge clk) begin
    s2_g  <= grad_mem[gaddr];
    s2_c  <= s1_c;
    s2_hx <= hpx[2*F:F];
    s2_hy <= hpy[2*F:F];
    s2_hz <= hpz[2*F:F];
    s2_ux <= s1_ux;
    s2_uy <= s1_uy;
    s2_uz <= s1_uz;
  end

  // stage 2: dot product and first weight product
  logic signed [F+1:0]  ox, oy, oz;
  logic signed [F+19:0] dsum;
  logic [F:0]           wx, wy, wz;
  logic [2*F+1:0]       wxy_p;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  assign ox = s2_c[2] ? $signed({2'b00, s2_ux}) - $signed({2'b01, {F{1'b0}}})
                      : $signed({2'b00, s2_ux});
  assign oy = s2_c[1] ? $signed({2'b00, s2_uy}) - $signed({2'b01, {F{1'b0}}})
                      : $signed({2'b00, s2_uy});
  assign oz = s2_c[0] ? $signed({2'b00, s2_uz}) - $signed({2'b01, {F{1'b0}}})
                      : $signed({2'b00, s2_uz});
  assign dsum = ($signed(s2_g[47:32]) * ox) + ($signed(s2_g[31:16]) * oy) +
                ($signed(s2_g[15:0]) * oz);
  assign wx    = s2_c[2] ? s2_hx : ONE - s2_hx;
  assign wy    = s2_c[1] ? s2_hy : ONE - s2_hy;
  assign wz    = s2_c[0] ? s2_hz : ONE - s2_hz;
  assign wxy_p = wx * wy;

  pgn3_pkg::tag_t      s3_tag;
  logic signed [F+4:0] s3_dot;
  logic [F:0]          s3_wxy, s3_wz;

  always_ff @(posedge clk) begin
    s3_dot <= dsum[F+19:15];
    s3_wxy <= wxy_p[2*F:F];
    s3_wz  <= wz;
  end

  // stage 3: corner weight
  logic [2*F+1:0] w_p;
  assign w_p = s3_wxy * s3_wz;

  pgn3_pkg::tag_t      s4_tag;
  logic signed [F+4:0] s4_dot;
  logic [F:0]          s4_w;

  always_ff @(posedge clk) begin
    s4_dot <= s3_dot;
    s4_w   <= w_p[2*F:F];
  end

  // stage 4: weighted term
  logic signed [2*F+6:0] tp;
  assign tp = $signed({1'b0, s4_w}) * s4_dot;

  pgn3_pkg::tag_t      s5_tag;
  logic signed [F+6:0] s5_term;

  always_ff @(posedge clk) begin
    s5_term <= tp[2*F+6:F];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
      s4_tag <= '0;
      s5_tag <= '0;
    end else begin
      s1_tag <= s0_tag;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
      s5_tag <= s4_tag;
    end
  end

  // stage 5: octave and item accumulation
  logic signed [NZ_W-1:0]  noise_acc_r, noise_new, noise_sh;
  logic signed [ACC_W-1:0] total_r, total_new, s6_total;
  logic                    s6_fire, s6_turb;

  assign noise_new = noise_acc_r + NZ_W'(s5_term);
  assign noise_sh  = noise_new >>> s5_tag.oct;
  assign total_new = total_r + ACC_W'(noise_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_acc_r <= '0;
      total_r     <= '0;
      s6_fire     <= 1'b0;
    end else begin
      s6_fire <= s5_tag.v && s5_tag.last_corner && s5_tag.last_oct;
      if (s5_tag.v) begin
        noise_acc_r <= s5_tag.last_corner ? '0 : noise_new;
        if (s5_tag.last_corner) begin
          total_r <= s5_tag.last_oct ? '0 : total_new;
        end
      end
    end
    s6_total <= total_new;
    s6_turb  <= s5_tag.turb;
  end

  // stage 6: turbulence magnitude and saturation
  logic signed [ACC_W-1:0] mag;
  logic signed [63:0]      mag64;
  logic signed [31:0]      sat;

  assign mag   = (s6_turb && s6_total[ACC_W-1]) ? -s6_total : s6_total;
  assign mag64 = {{(64-ACC_W){mag[ACC_W-1]}}, mag};

  always_comb begin
    if (mag64 > 64'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (mag64 < -64'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = mag64[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s6_fire;
    end
    out_noise_value    <= sat;
    out_was_turbulence <= s6_turb;
  end

  `PGN3_ASSERT_NEXT(a_result_follows, s5_tag.v && s5_tag.last_corner && s5_tag.last_oct, ##1 out_valid)
  `PGN3_ASSERT_IMPLY(a_strobe_source, out_valid, $past(s5_tag.v && s5_tag.last_corner && s5_tag.last_oct, 2))
  `PGN3_ASSERT_NEXT(a_corner_step, active_r && corner_r != 3'd7, active_r && corner_r == $past(corner_r) + 3'd1)
  `PGN3_ASSERT_IMPLY(a_pop_when_free, q_pop, !q_empty && (!active_r || item_end))

endmodule
